// ===== rtl/rmf_pkg.sv =====
// Shared types and constants for the running median filter.
`default_nettype none

package rmf_pkg;

    // Width of the window size register
    localparam int CFG_WIDTH = 7;

    // Window size after reset
    localparam logic [CFG_WIDTH-1:0] WINDOW_RESET = CFG_WIDTH'(9);

    // Status that each cell shows its neighbors
    typedef struct packed {
        logic valid;     // cell holds a sample of the window
        logic le_new;    // cell value <= incoming sample (valid cells only)
        logic ge_old;    // cell value >= sample leaving the window
    } cell_flags_t;

    // Controls broadcast to every cell
    typedef struct packed {
        logic accept;    // an item is taken this cycle
        logic clear;     // drop all samples (stream end or new window size)
        logic full;      // window is full, the oldest sample leaves
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/rmf_cell.sv =====
// One cell of the sorted sample chain: value, age and valid bit.
`default_nettype none

module rmf_cell
    import rmf_pkg::*;
#(
    parameter int SW = 24,
    parameter int AW = 6
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire cell_ctrl_t      ctrl,
    input  wire signed [SW-1:0]  new_value,
    input  wire signed [SW-1:0]  old_value,
    // lower neighbor
    input  wire cell_flags_t     lo_flags,
    input  wire signed [SW-1:0]  lo_value,
    input  wire [AW-1:0]         lo_age,
    // upper neighbor
    input  wire cell_flags_t     up_flags,
    input  wire signed [SW-1:0]  up_value,
    input  wire [AW-1:0]         up_age,
    // this cell
    output cell_flags_t          flags,
    output logic signed [SW-1:0] value,
    output logic [AW-1:0]        age
);

    logic signed [SW-1:0] value_reg;
    logic signed [SW-1:0] value_next;
    logic [AW-1:0]        age_reg;
    logic [AW-1:0]        age_next;
    logic                 valid_reg;
    logic                 valid_next;

    logic                 kept_le_here;
    logic                 kept_le_below;
    logic signed [SW-1:0] kept_value_here;
    logic signed [SW-1:0] kept_value_below;
    logic [AW-1:0]        kept_age_here;
    logic [AW-1:0]        kept_age_below;

    // local compares against the incoming and the leaving sample
    assign flags.valid  = valid_reg;
    assign flags.le_new = valid_reg && (value_reg <= new_value);
    assign flags.ge_old = ctrl.full && valid_reg && (value_reg >= old_value);
    assign value        = value_reg;
    assign age          = age_reg;

    // list after removal: slot moves down by one at and above the leaving sample
    always_comb begin
        kept_le_here     = flags.ge_old ? up_flags.le_new : flags.le_new;
        kept_value_here  = flags.ge_old ? up_value : value_reg;
        kept_age_here    = flags.ge_old ? up_age : age_reg;
        kept_le_below    = lo_flags.ge_old ? flags.le_new : lo_flags.le_new;
        kept_value_below = lo_flags.ge_old ? value_reg : lo_value;
        kept_age_below   = lo_flags.ge_old ? age_reg : lo_age;
    end

    // insertion: stay, take the new sample, or take the one below
    always_comb begin
        if (kept_le_here) begin
            value_next = kept_value_here;
            age_next   = kept_age_here + AW'(1);
        end else if (kept_le_below) begin
            value_next = new_value;
            age_next   = '0;
        end else begin
            value_next = kept_value_below;
            age_next   = kept_age_below + AW'(1);
        end
        valid_next = valid_reg || (!ctrl.full && lo_flags.valid);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.accept) begin
            value_reg <= value_next;
            age_reg   <= age_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctrl.clear) begin
            valid_reg <= 1'b0;
        end else if (ctrl.accept) begin
            valid_reg <= valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rmf_median.sv =====
// Output stages: middle values registered, then averaged into the result register.
`default_nettype none

module rmf_median #(
    parameter int SW = 24,
    parameter int TW = 24
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 advance,
    input  wire                 in_valid,
    input  wire                 in_last,
    input  wire signed [SW-1:0] lo_value,
    input  wire signed [SW-1:0] hi_value,
    output logic                m_tvalid,
    output logic [TW-1:0]       m_tdata,
    output logic                m_tlast
);

    logic                 mid_valid_reg;
    logic                 mid_last_reg;
    logic signed [SW-1:0] mid_lo_reg;
    logic signed [SW-1:0] mid_hi_reg;
    logic signed [SW:0]   mid_sum;
    logic                 out_valid_reg;
    logic                 out_last_reg;
    logic signed [SW-1:0] out_value_reg;

    // exact sum, then floor halving by arithmetic shift
    assign mid_sum = {mid_lo_reg[SW-1], mid_lo_reg} + {mid_hi_reg[SW-1], mid_hi_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            mid_valid_reg <= in_valid;
            out_valid_reg <= mid_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            mid_last_reg  <= in_last;
            mid_lo_reg    <= lo_value;
            mid_hi_reg    <= hi_value;
            out_last_reg  <= mid_last_reg;
            out_value_reg <= mid_sum[SW:1];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TW'($unsigned(out_value_reg));
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ===== rtl/running_median_filter_core.sv =====
// Running median filter: sorted cell chain, window control and result pipeline.
// Pipeline: an accepted item loads p1, then the middle registers, then the result register.
// Throughput: one item per cycle; the whole sorted chain shifts at once, and
// the pipeline stalls as a unit while a result waits with m_tready low.
// Reset: aresetn (synchronous, active low) empties the window and the pipeline and
// sets the window size to 9. Stored sample values are not cleared.
`default_nettype none

module running_median_filter_core
    import rmf_pkg::*;
#(
    parameter int MAX_WINDOW   = 64,
    parameter int SAMPLE_WIDTH = 24
) (
    input  wire                      aclk,
    input  wire                      aresetn,
    // configuration: window size
    input  wire                      cfg_valid,
    output logic                     cfg_ready,
    input  wire [CFG_WIDTH-1:0]      cfg_data,
    // input items
    input  wire                      s_tvalid,
    output logic                     s_tready,
    input  wire [((SAMPLE_WIDTH+7)/8)*8-1:0]  s_tdata,   // [SAMPLE_WIDTH-1:0] sample, rest zero
    input  wire                      s_tlast,   // last_sample
    // result items
    output logic                     m_tvalid,
    input  wire                      m_tready,
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0] m_tdata,   // [SAMPLE_WIDTH-1:0] median, rest zero
    output logic                     m_tlast    // stream_end
);

    localparam int DATA_BYTES = (SAMPLE_WIDTH + 7) / 8;
    localparam int TW         = DATA_BYTES * 8;
    localparam int CW         = $clog2(MAX_WINDOW + 1);
    localparam int AW         = $clog2(MAX_WINDOW);

    logic [CFG_WIDTH-1:0]     window_reg;
    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            count_next;
    logic signed [SAMPLE_WIDTH-1:0] old_reg;
    logic signed [SAMPLE_WIDTH-1:0] old_next;
    logic                     p1_valid_reg;
    logic                     p1_last_reg;

    logic [31:0]              window_wide;
    logic [CW-1:0]            win;
    logic [CW-1:0]            lo_idx;
    logic [CW-1:0]            hi_idx;
    logic                     full;
    logic                     produced;
    logic                     advance;
    logic                     accept;
    logic                     cfg_write;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    cell_ctrl_t               ctrl;

    // chain links: index 0 is the bottom end, MAX_WINDOW+1 the top end
    cell_flags_t              link_flags [MAX_WINDOW+2];
    logic signed [SAMPLE_WIDTH-1:0] link_value [MAX_WINDOW+2];
    logic [AW-1:0]            link_age [MAX_WINDOW+2];
    logic [MAX_WINDOW-1:0]    valid_vec;

    logic signed [SAMPLE_WIDTH-1:0] lo_value;
    logic signed [SAMPLE_WIDTH-1:0] hi_value;
    logic signed [SAMPLE_WIDTH-1:0] next_oldest;

    assign sample    = s_tdata[SAMPLE_WIDTH-1:0];
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // effective window: zero acts as one, large values saturate
    always_comb begin
        window_wide = 32'(window_reg);
        if (window_wide == 32'd0) begin
            win = CW'(1);
        end else if (window_wide > 32'(MAX_WINDOW)) begin
            win = CW'(MAX_WINDOW);
        end else begin
            win = window_wide[CW-1:0];
        end
        lo_idx = (win - CW'(1)) >> 1;
        hi_idx = win >> 1;
    end

    // pipeline moves as a unit when the result register can take data
    assign advance  = !m_tvalid || m_tready;
    assign s_tready = advance;
    assign accept   = s_tvalid && s_tready;

    assign full     = (count_reg == win);
    assign produced = full || (count_reg + CW'(1) == win);

    assign ctrl.accept = accept;
    assign ctrl.clear  = cfg_write || (accept && s_tlast);
    assign ctrl.full   = full;

    // fill count
    always_comb begin
        count_next = count_reg;
        if (cfg_write || (accept && s_tlast)) begin
            count_next = '0;
        end else if (accept && !full) begin
            count_next = count_reg + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg   <= WINDOW_RESET;
            count_reg    <= '0;
            p1_valid_reg <= 1'b0;
        end else begin
            if (cfg_write) begin
                window_reg <= cfg_data;
            end
            count_reg <= count_next;
            if (advance) begin
                p1_valid_reg <= accept && produced;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            p1_last_reg <= s_tlast;
        end
        if (accept) begin
            old_reg <= old_next;
        end
    end

    // chain ends
    assign link_flags[0]            = '{valid: 1'b1, le_new: 1'b1, ge_old: 1'b0};
    assign link_value[0]            = '0;
    assign link_age[0]              = '0;
    assign link_flags[MAX_WINDOW+1] = '{valid: 1'b0, le_new: 1'b0, ge_old: 1'b0};
    assign link_value[MAX_WINDOW+1] = '0;
    assign link_age[MAX_WINDOW+1]   = '0;

    // sorted cell chain, lowest value in cell 0
    for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
        rmf_cell #(
            .SW (SAMPLE_WIDTH),
            .AW (AW)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .new_value (sample),
            .old_value (old_reg),
            .lo_flags  (link_flags[i]),
            .lo_value  (link_value[i]),
            .lo_age    (link_age[i]),
            .up_flags  (link_flags[i+2]),
            .up_value  (link_value[i+2]),
            .up_age    (link_age[i+2]),
            .flags     (link_flags[i+1]),
            .value     (link_value[i+1]),
            .age       (link_age[i+1])
        );
        assign valid_vec[i] = link_flags[i+1].valid;
    end

    // middle values for the median and the sample that leaves next
    always_comb begin
        lo_value    = '0;
        hi_value    = '0;
        next_oldest = '0;
        for (int i = 0; i < MAX_WINDOW; i++) begin
            if (CW'(i) == lo_idx) begin
                lo_value = lo_value | link_value[i+1];
            end
            if (CW'(i) == hi_idx) begin
                hi_value = hi_value | link_value[i+1];
            end
            if (link_flags[i+1].valid && (CW'(link_age[i+1]) == win - CW'(2))) begin
                next_oldest = next_oldest | link_value[i+1];
            end
        end
        old_next = (win == CW'(1)) ? sample : next_oldest;
    end

    rmf_median #(
        .SW (SAMPLE_WIDTH),
        .TW (TW)
    ) u_median (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .in_valid (p1_valid_reg),
        .in_last  (p1_last_reg),
        .lo_value (lo_value),
        .hi_value (hi_value),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // fill count never passes the window
    a_count_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= win)
        else $error("fill count above window size");

    // occupied cells match the fill count
    a_count_matches_cells: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_vec) == 32'(count_reg))
        else $error("cell occupancy differs from fill count");

    // occupied cells stay in ascending order
    for (genvar i = 0; i + 1 < MAX_WINDOW; i++) begin : g_order_chk
        a_sorted: assert property (@(posedge aclk) disable iff (!aresetn)
            valid_vec[i+1] |-> (valid_vec[i] && link_value[i+1] <= link_value[i+2]))
            else $error("cell chain out of order");
    end

endmodule

`default_nettype wire
